// ===== rtl/core/wsd_pkg.sv =====
package wsd_pkg;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNMASKED    = 2'd1;
    localparam logic [1:0] ST_RESERVED_OP = 2'd2;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_payload;
        logic        fin;
        logic [3:0]  frame_opcode;
        logic        frame_end;
        logic [63:0] frame_length;
        logic [1:0]  status;
    } result_t;

    function automatic logic opcode_known(input logic [3:0] op);
        return op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    endfunction

endpackage

// ===== rtl/core/websocket_frame_deframer_core.sv =====
// channel  | ports                                  | moves
// ---------+----------------------------------------+---------------------------------
// input    | s_valid s_ready s_in_byte              | one stream byte per request
// result   | m_valid m_ready m_data_byte m_is_payload| one payload byte or end marker
//          | m_fin m_frame_opcode m_frame_end       |
//          | m_frame_length m_status                |
//
// one byte per cycle sustained while m_ready is high; a result reaches the result ports through
// the input register, the combinational parser and the result register
// header bytes give no result except the end marker of an empty frame
// aresetn is synchronous, active low, and returns the parser to the first header byte
// a stalled result register holds the parser; one further byte waits in the input register
module websocket_frame_deframer_core
    import wsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_is_payload,
    output logic        m_fin,
    output logic [3:0]  m_frame_opcode,
    output logic        m_frame_end,
    output logic [63:0] m_frame_length,
    output logic [1:0]  m_status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_ready;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    assign advance = in_valid_reg && out_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (res_valid),
        .up_ready (out_ready),
        .up_res   (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_data_byte    = m_res.data_byte;
    assign m_is_payload   = m_res.is_payload;
    assign m_fin          = m_res.fin;
    assign m_frame_opcode = m_res.frame_opcode;
    assign m_frame_end    = m_res.frame_end;
    assign m_frame_length = m_res.frame_length;
    assign m_status       = m_res.status;

endmodule

// ===== rtl/core/wsd_parser.sv =====
module wsd_parser
    import wsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  in_byte,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] length_reg, length_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [1:0]  key_index_reg, key_index_next;
    logic [1:0]  error_reg, error_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HDR0;
            header_count_reg <= '0;
            fin_reg          <= 1'b1;
            opcode_reg       <= OP_CLOSE;
            masked_reg       <= 1'b1;
            length_reg       <= '0;
            key_reg          <= '0;
            remaining_reg    <= '0;
            key_index_reg    <= '0;
            error_reg        <= ST_OK;
        end else begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            masked_reg       <= masked_next;
            length_reg       <= length_next;
            key_reg          <= key_next;
            remaining_reg    <= remaining_next;
            key_index_reg    <= key_index_next;
            error_reg        <= error_next;
        end
    end

    always_comb begin
        logic       go_length_done;
        logic       go_begin;
        logic [7:0] k;

        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        masked_next       = masked_reg;
        length_next       = length_reg;
        key_next          = key_reg;
        remaining_next    = remaining_reg;
        key_index_next    = key_index_reg;
        error_next        = error_reg;
        go_length_done    = 1'b0;
        go_begin          = 1'b0;
        k                 = '0;
        res_valid         = 1'b0;
        res.data_byte     = '0;
        res.is_payload    = 1'b0;
        res.frame_end     = 1'b0;

        if (advance) begin
            case (phase_reg)
                PH_HDR1: begin
                    masked_next = in_byte[7];
                    if (!opcode_known(opcode_reg)) begin
                        error_next = ST_RESERVED_OP;
                    end else if (!in_byte[7]) begin
                        error_next = ST_UNMASKED;
                    end else begin
                        error_next = ST_OK;
                    end
                    length_next = '0;
                    if (in_byte[6:0] == LEN_EXT16) begin
                        header_count_next = EXT16_BYTES;
                        phase_next        = PH_EXT;
                    end else if (in_byte[6:0] == LEN_EXT64) begin
                        header_count_next = EXT64_BYTES;
                        phase_next        = PH_EXT;
                    end else begin
                        length_next    = {57'd0, in_byte[6:0]};
                        go_length_done = 1'b1;
                    end
                end
                PH_EXT: begin
                    // big-endian, shift in one byte per request
                    length_next       = {length_reg[55:0], in_byte};
                    header_count_next = header_count_reg - 4'd1;
                    go_length_done    = (header_count_reg == 4'd1);
                end
                PH_KEY: begin
                    key_next          = {key_reg[23:0], in_byte};
                    header_count_next = header_count_reg - 4'd1;
                    go_begin          = (header_count_reg == 4'd1);
                end
                PH_DATA: begin
                    if (masked_reg) begin
                        case (key_index_reg)
                            2'd0:    k = key_reg[31:24];
                            2'd1:    k = key_reg[23:16];
                            2'd2:    k = key_reg[15:8];
                            default: k = key_reg[7:0];
                        endcase
                    end
                    key_index_next = key_index_reg + 2'd1;
                    remaining_next = remaining_reg - 64'd1;
                    res_valid      = 1'b1;
                    res.data_byte  = in_byte ^ k;
                    res.is_payload = 1'b1;
                    res.frame_end  = (remaining_reg == 64'd1);
                    if (remaining_reg == 64'd1) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            if (go_length_done) begin
                if (masked_next) begin
                    header_count_next = KEY_BYTES;
                    key_next          = '0;
                    phase_next        = PH_KEY;
                end else begin
                    go_begin = 1'b1;
                end
            end

            if (go_begin) begin
                if (length_next == 64'd0) begin
                    // empty frame: end marker on the last header byte
                    phase_next    = PH_HDR0;
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                end else begin
                    remaining_next = length_next;
                    key_index_next = '0;
                    phase_next     = PH_DATA;
                end
            end
        end

        res.fin          = fin_next;
        res.frame_opcode = opcode_next;
        res.frame_length = length_next;
        res.status       = error_next;
    end

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");

    a_data_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (remaining_reg != 64'd0))
        else $error("payload phase with no bytes left");

    a_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_EXT || phase_reg == PH_KEY) |-> (header_count_reg != 4'd0))
        else $error("header byte count exhausted in header phase");

    a_marker_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.is_payload) |-> (res.frame_end && res.data_byte == 8'd0
            && res.frame_length == 64'd0))
        else $error("malformed empty-frame end marker");

    a_end_leaves_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.frame_end) |=> (phase_reg == PH_HDR0))
        else $error("frame end without return to first header byte");

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
module wsd_out_stage
    import wsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    up_valid,
    output logic    up_ready,
    input  result_t up_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign up_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            res_reg <= up_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import wsd_pkg::*;

    localparam int RANDOM_BYTES = 1450;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [7:0] val;
        logic       wait_idle;
    } stream_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data_byte;
    logic        m_is_payload;
    logic        m_fin;
    logic [3:0]  m_frame_opcode;
    logic        m_frame_end;
    logic [63:0] m_frame_length;
    logic [1:0]  m_status;

    stream_item_t stream_q[$];
    result_t      due_results[$];
    int           total_bytes;
    int           bytes_taken = 0;
    int           errors = 0;
    int           cycles = 0;

    // parser copy
    phase_t      p_phase;
    logic [3:0]  p_count;
    logic        p_fin;
    logic [3:0]  p_opcode;
    logic        p_masked;
    logic [63:0] p_len;
    logic [31:0] p_key;
    logic [63:0] p_left;
    logic [1:0]  p_kidx;
    logic [1:0]  p_status;

    // sender and receiver pacing
    logic next_valid;
    int   gap_left = 0;
    int   burst_left = 0;
    int   rx_tick = 0;
    int   rx_mode = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    logic rdy;
    logic [7:0] rx_pattern = 8'b1011_0110;
    result_t got;

    websocket_frame_deframer_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_byte    (m_data_byte),
        .m_is_payload   (m_is_payload),
        .m_fin          (m_fin),
        .m_frame_opcode (m_frame_opcode),
        .m_frame_end    (m_frame_end),
        .m_frame_length (m_frame_length),
        .m_status       (m_status)
    );

    always #6 aclk = ~aclk;

    function automatic logic op_listed(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("data=%h pay=%0d fin=%0d op=%h end=%0d len=%h st=%0d",
                         r.data_byte, r.is_payload, r.fin, r.frame_opcode,
                         r.frame_end, r.frame_length, r.status);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        result_t    r;
        logic       emit;
        logic       len_done;
        logic       key_done;
        logic [7:0] kb;
        r = '0;
        emit = 1'b0;
        len_done = 1'b0;
        key_done = 1'b0;
        case (p_phase)
            PH_HDR1: begin
                p_masked = b[7];
                if (!op_listed(p_opcode))
                    p_status = ST_RESERVED_OP;
                else if (!b[7])
                    p_status = ST_UNMASKED;
                else
                    p_status = ST_OK;
                p_len = '0;
                if (b[6:0] == LEN_EXT16) begin
                    p_count = EXT16_BYTES;
                    p_phase = PH_EXT;
                end else if (b[6:0] == LEN_EXT64) begin
                    p_count = EXT64_BYTES;
                    p_phase = PH_EXT;
                end else begin
                    p_len = {57'd0, b[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                p_len = {p_len[55:0], b};
                p_count = p_count - 4'd1;
                len_done = (p_count == 4'd0);
            end
            PH_KEY: begin
                p_key = {p_key[23:0], b};
                p_count = p_count - 4'd1;
                key_done = (p_count == 4'd0);
            end
            PH_DATA: begin
                kb = p_masked ? p_key[8 * (3 - p_kidx) +: 8] : 8'h00;
                p_kidx = p_kidx + 2'd1;
                p_left = p_left - 64'd1;
                r.data_byte = b ^ kb;
                r.is_payload = 1'b1;
                r.frame_end = (p_left == 64'd0);
                if (r.frame_end)
                    p_phase = PH_HDR0;
                emit = 1'b1;
            end
            default: begin
                p_fin = b[7];
                p_opcode = b[3:0];
                p_phase = PH_HDR1;
            end
        endcase
        if (len_done) begin
            if (p_masked) begin
                p_count = KEY_BYTES;
                p_key = '0;
                p_phase = PH_KEY;
            end else begin
                key_done = 1'b1;
            end
        end
        if (key_done) begin
            if (p_len == 64'd0) begin
                // empty frame closes on its last header byte
                p_phase = PH_HDR0;
                r.frame_end = 1'b1;
                emit = 1'b1;
            end else begin
                p_left = p_len;
                p_kidx = 2'd0;
                p_phase = PH_DATA;
            end
        end
        if (emit) begin
            r.fin = p_fin;
            r.frame_opcode = p_opcode;
            r.frame_length = p_len;
            r.status = p_status;
            due_results.push_back(r);
        end
    endtask

    task automatic queue_byte(input logic [7:0] v, input logic w);
        stream_q.push_back('{val: v, wait_idle: w});
    endtask

    // form: 0 short length, 1 16-bit extended, 2 64-bit extended
    task automatic add_frame(input logic [7:0] h0, input logic masked, input int form,
                             input logic [63:0] len, input int n_pay,
                             input logic [31:0] key, input logic w);
        logic [6:0] code;
        code = (form == 1) ? LEN_EXT16 : (form == 2) ? LEN_EXT64 : len[6:0];
        queue_byte(h0, w);
        queue_byte({masked, code}, 1'b0);
        if (form == 1) begin
            queue_byte(len[15:8], 1'b0);
            queue_byte(len[7:0], 1'b0);
        end
        if (form == 2)
            for (int i = 7; i >= 0; i--)
                queue_byte(len[8 * i +: 8], 1'b0);
        if (masked)
            for (int i = 3; i >= 0; i--)
                queue_byte(key[8 * i +: 8], 1'b0);
        repeat (n_pay)
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // sender: one request per handshake, bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'h00;
            p_phase = PH_HDR0;
            p_count = '0;
            p_fin = 1'b1;
            p_opcode = OP_CLOSE;
            p_masked = 1'b1;
            p_len = '0;
            p_key = '0;
            p_left = '0;
            p_kidx = '0;
            p_status = ST_OK;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                deframe_byte(s_in_byte);
                bytes_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid && stream_q.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!stream_q[0].wait_idle || due_results.size() == 0) begin
                    s_in_byte <= stream_q[0].val;
                    stream_q.pop_front();
                    next_valid = 1'b1;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 4) == 0) begin
                            gap_left = 0;
                            burst_left = $urandom_range(60, 200);
                        end else begin
                            gap_left = $urandom_range(0, 7);
                            burst_left = $urandom_range(1, 30);
                        end
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver: changing stall pattern plus two long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_tick % 200 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (holds_done < 2 && bytes_taken >= (holds_done == 0 ? 300 : 1000)) begin
                hold_left = 250;
                holds_done++;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 3) != 0);
                    default: begin
                        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
                        rdy = rx_pattern[0];
                    end
                endcase
            end
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = '{data_byte: m_data_byte, is_payload: m_is_payload, fin: m_fin,
                    frame_opcode: m_frame_opcode, frame_end: m_frame_end,
                    frame_length: m_frame_length, status: m_status};
            if (due_results.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: %s", show(got));
                errors++;
            end else begin
                if (got.data_byte !== due_results[0].data_byte
                        || got.is_payload !== due_results[0].is_payload
                        || got.fin !== due_results[0].fin
                        || got.frame_opcode !== due_results[0].frame_opcode
                        || got.frame_end !== due_results[0].frame_end
                        || got.frame_length !== due_results[0].frame_length
                        || got.status !== due_results[0].status) begin
                    if (errors < 10) begin
                        $display("mismatch exp: %s", show(due_results[0]));
                        $display("         got: %s", show(got));
                    end
                    errors++;
                end
                void'(due_results.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [3:0]  ops[6];
        logic [7:0]  h0;
        logic        masked;
        logic [63:0] len;
        int          form;
        int          pick;
        int          nframes;
        ops = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
        nframes = 0;

        // directed frames
        add_frame({1'b1, 3'b000, OP_TEXT}, 1'b1, 0, 64'd1, 1, 32'hFFFF_FFFF, 1'b0);
        add_frame({1'b0, 3'b111, OP_CONT}, 1'b0, 0, 64'd0, 0, 32'h0, 1'b0);
        add_frame({1'b1, 3'b000, 4'hF}, 1'b0, 0, 64'd1, 1, 32'h0, 1'b0);
        add_frame({1'b0, 3'b000, OP_BINARY}, 1'b0, 1, 64'd0, 0, 32'h0, 1'b0);
        add_frame({1'b1, 3'b000, OP_PING}, 1'b1, 0, 64'd0, 0, 32'h0000_0000, 1'b0);
        add_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, 0, 64'd0, 0, 32'h0, 1'b0);
        add_frame({1'b1, 3'b000, OP_PONG}, 1'b0, 0, 64'd1, 1, 32'h0, 1'b0);

        while (stream_q.size() < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                h0 = 8'($urandom_range(0, 255));
            else
                h0 = {1'($urandom_range(0, 1)), 3'b000, ops[$urandom_range(0, 5)]};
            masked = ($urandom_range(0, 9) < 8);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                form = 0;
                len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
                                                 : 64'($urandom_range(0, 12));
            end else if (pick < 88) begin
                form = 1;
                len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 400))
                                                 : 64'($urandom_range(0, 40));
            end else begin
                form = 2;
                len = 64'($urandom_range(0, 60));
            end
            add_frame(h0, masked, form, len, int'(len), $urandom(), (nframes % 25 == 0));
            nframes++;
        end
        // huge 64-bit length, never completes within the run
        add_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 2, '1, 200, $urandom(), 1'b1);
        total_bytes = stream_q.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken != total_bytes)
            @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/wsd_pkg.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_out_stage.sv
rtl/core/websocket_frame_deframer_core.sv
tb/testbench.sv
